// ----- rtl/core/assert_macros.svh -----
// Assertion macros for the RTL files of the draw engine.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Property checked on every rising clock edge outside reset.
`define MFDE_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("mfde assertion failed");
// Condition on one edge implies a consequence on the next edge.
`define MFDE_ASSERT_NEXT(lbl, clk, rstn, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
    else $error("mfde assertion failed");
`else
`define MFDE_ASSERT(lbl, clk, rstn, prop)
`define MFDE_ASSERT_NEXT(lbl, clk, rstn, pre, post)
`endif

`endif

// ----- rtl/core/mfde_pkg.sv -----
// Package: geometry constants, command codes and transfer payload types.
`timescale 1ns / 1ps

package mfde_pkg;

  localparam int DISPLAY_COLUMNS = 128;
  localparam int DISPLAY_PAGES   = 8;

  localparam int STORE_BYTES  = DISPLAY_COLUMNS * DISPLAY_PAGES;
  localparam int DISPLAY_ROWS = 8 * DISPLAY_PAGES;
  localparam int CURSOR_BYTES = 3;
  localparam int FRAME_BYTES  = STORE_BYTES + CURSOR_BYTES;

  localparam int ADDR_W = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
  localparam int POS_W  = $clog2(FRAME_BYTES);
  // Coordinates as drawn: column plus rectangle length, before clipping.
  localparam int CRD_W  = 9;

  localparam logic [7:0] CURSOR_PAGE   = 8'hB0;
  localparam logic [7:0] CURSOR_COL_HI = 8'h10;
  localparam logic [7:0] CURSOR_COL_LO = 8'h00;
  localparam logic [7:0] FILL_BYTE     = 8'hFF;
  localparam logic [7:0] CLEAR_BYTE    = 8'h00;

  typedef enum logic [2:0] {
    CMD_CLEAR  = 3'd0,
    CMD_FILL   = 3'd1,
    CMD_POINT  = 3'd2,
    CMD_LINE   = 3'd3,
    CMD_RECT   = 3'd4,
    CMD_STREAM = 3'd5
  } cmd_e;

  typedef struct packed {
    logic [2:0] command;
    logic [5:0] row_a;
    logic [6:0] col_a;
    logic [5:0] row_b;
    logic [6:0] col_b;
    logic [7:0] rect_length;
    logic [6:0] rect_width;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_data;
    logic       frame_last;
    logic       done_res;
  } out_item_t;

  // One straight run of pixels: fixed row (horizontal) or column (vertical).
  typedef struct packed {
    logic             vert;
    logic             empty;
    logic [CRD_W-1:0] fix;
    logic [CRD_W-1:0] lo;
    logic [CRD_W-1:0] hi;
  } seg_t;

endpackage

// ----- rtl/core/mfde_if.sv -----
// Valid/ready channel interfaces for commands and results.
`timescale 1ns / 1ps

interface mfde_in_if;
  mfde_pkg::in_item_t data;
  logic               valid;
  logic               ready;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface mfde_out_if;
  mfde_pkg::out_item_t data;
  logic                valid;
  logic                ready;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/core/mfde_ram.sv -----
// Generic single-clock RAM, one write port and one registered read port.
`timescale 1ns / 1ps

module mfde_ram #(
  parameter int Width = 8,
  parameter int Depth = 1024
) (
  input  logic                                         clk_i,
  input  logic                                         we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                             wdata_i,
  input  logic                                         re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                             rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    if (re_i) rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/mono_framebuffer_draw_engine.sv -----
// Top level: page-organised monochrome framebuffer with draw engine.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Usage
// - cmd_i carries one command per transfer: clear, fill, point, line,
//   rectangle outline, or stream (return next display refresh byte).
// - res_o returns exactly one result per command. Draw, clear and fill
//   report done_res; stream returns cursor bytes B0/10/00 and then every
//   store byte with is_data set, frame_last on the final one.
// - A diagonal or reversed line draws nothing; a rectangle outline walks
//   its edge pixels, folding a start row past the bottom into range. The
//   pixel loop does one read-modify-write per cycle through the frame RAM.
// - One command is processed at a time; cmd_i.ready is high only while
//   the engine is idle, but a waiting result does not block the next
//   command from being taken.
// - Reset: once rst_ni is released the store is cleared by a pass over
//   all STORE_BYTES bytes, during which no command is taken. The
//   stream position returns to the first cursor byte.
// - Receiver stall: the result sits in the output register; a finished
//   command waits for it to drain before its own result is loaded.
module mono_framebuffer_draw_engine (
  input  logic             clk_i,
  input  logic             rst_ni,
  mfde_in_if.sink          cmd_i,
  mfde_out_if.source       res_o
);

  localparam int ADDR_W = mfde_pkg::ADDR_W;
  localparam int POS_W  = mfde_pkg::POS_W;
  localparam int CRD_W  = mfde_pkg::CRD_W;

  localparam logic [CRD_W-1:0]  COL_LIMIT  = CRD_W'(mfde_pkg::DISPLAY_COLUMNS);
  localparam logic [CRD_W-1:0]  COL_MAX    = CRD_W'(mfde_pkg::DISPLAY_COLUMNS - 1);
  localparam logic [CRD_W-1:0]  ROW_LIMIT  = CRD_W'(mfde_pkg::DISPLAY_ROWS);
  localparam logic [CRD_W-1:0]  ROW_MAX    = CRD_W'(mfde_pkg::DISPLAY_ROWS - 1);
  localparam logic [ADDR_W-1:0] SWEEP_LAST = ADDR_W'(mfde_pkg::STORE_BYTES - 1);
  localparam logic [POS_W-1:0]  POS_LAST   = POS_W'(mfde_pkg::FRAME_BYTES - 1);

  typedef enum logic [6:0] {
    S_INIT  = 7'b000_0001,  // clearing pass after reset
    S_IDLE  = 7'b000_0010,
    S_SWEEP = 7'b000_0100,  // clear / fill
    S_SEG   = 7'b000_1000,  // pick next run of pixels
    S_WRAP  = 7'b001_0000,  // fold start row into display range
    S_DRAW  = 7'b010_0000,  // one pixel read per cycle
    S_RESP  = 7'b100_0000   // hand result to output register
  } state_e;

  state_e st_q, st_d;

  mfde_pkg::in_item_t  cmd_q, cmd_d;
  mfde_pkg::out_item_t res_q, res_d, out_q, out_d;
  logic                res_ram_q, res_ram_d;
  logic                out_valid_q, out_valid_d;

  logic [1:0]        seg_idx_q, seg_idx_d;
  logic [ADDR_W-1:0] swp_q, swp_d;
  logic              fill_q, fill_d;
  logic [POS_W-1:0]  pos_q, pos_d;

  // run walker
  logic             vert_q, vert_d;
  logic [CRD_W-1:0] cur_q, cur_d;
  logic [CRD_W-1:0] end_q, end_d;
  logic [CRD_W-1:0] colfix_q, colfix_d;
  logic [CRD_W-1:0] red_q, red_d;

  // read-modify-write pipe and one-deep forward
  logic              pend_valid_q, pend_valid_d;
  logic [ADDR_W-1:0] pend_addr_q, pend_addr_d;
  logic [7:0]        pend_mask_q, pend_mask_d;
  logic              fwd_valid_q;
  logic [ADDR_W-1:0] fwd_addr_q;
  logic [7:0]        fwd_data_q;

  // RAM port
  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [7:0]        ram_wdata, ram_rdata;

  logic             cmd_fire;
  mfde_pkg::seg_t   seg;
  logic             seg_last, seg_skip;
  logic [CRD_W-1:0] r_end, c_end, pix_col, page;
  logic [ADDR_W-1:0] pix_addr;
  logic [7:0]        pix_base, pix_wdata;
  logic              out_free;
  logic              sweeping, stream_fire;

  assign cmd_i.ready = (st_q == S_IDLE);
  assign cmd_fire    = cmd_i.valid && cmd_i.ready;
  assign res_o.valid = out_valid_q;
  assign res_o.data  = out_q;
  assign out_free    = !out_valid_q || res_o.ready;
  assign sweeping    = (st_q == S_INIT) || (st_q == S_SWEEP);
  assign stream_fire = cmd_fire && (cmd_i.data.command == mfde_pkg::CMD_STREAM);

  // --- run decode: each draw command is up to four straight runs ---
  assign r_end = CRD_W'(cmd_q.row_a) + CRD_W'(cmd_q.rect_width) - CRD_W'(1);
  assign c_end = CRD_W'(cmd_q.col_a) + CRD_W'(cmd_q.rect_length) - CRD_W'(1);

  always_comb begin
    seg       = '0;
    seg.empty = 1'b1;
    seg_last  = 1'b1;
    case (cmd_q.command)
      mfde_pkg::CMD_POINT: begin
        seg.empty = 1'b0;
        seg.fix   = CRD_W'(cmd_q.row_a);
        seg.lo    = CRD_W'(cmd_q.col_a);
        seg.hi    = CRD_W'(cmd_q.col_a);
      end
      mfde_pkg::CMD_LINE: begin
        if (cmd_q.row_a == cmd_q.row_b) begin
          seg.empty = (cmd_q.col_a > cmd_q.col_b);
          seg.fix   = CRD_W'(cmd_q.row_a);
          seg.lo    = CRD_W'(cmd_q.col_a);
          seg.hi    = CRD_W'(cmd_q.col_b);
        end else if (cmd_q.col_a == cmd_q.col_b) begin
          seg.vert  = 1'b1;
          seg.empty = (cmd_q.row_a > cmd_q.row_b);
          seg.fix   = CRD_W'(cmd_q.col_a);
          seg.lo    = CRD_W'(cmd_q.row_a);
          seg.hi    = CRD_W'(cmd_q.row_b);
        end
        // diagonal: nothing drawn
      end
      mfde_pkg::CMD_RECT: begin
        seg_last  = (seg_idx_q == 2'd3);
        seg.empty = (cmd_q.rect_length == '0) || (cmd_q.rect_width == '0);
        case (seg_idx_q)
          2'd0: begin
            seg.fix = CRD_W'(cmd_q.row_a);
            seg.lo  = CRD_W'(cmd_q.col_a);
            seg.hi  = c_end;
          end
          2'd1: begin
            seg.fix = r_end;
            seg.lo  = CRD_W'(cmd_q.col_a);
            seg.hi  = c_end;
          end
          2'd2: begin
            seg.vert = 1'b1;
            seg.fix  = CRD_W'(cmd_q.col_a);
            seg.lo   = CRD_W'(cmd_q.row_a);
            seg.hi   = r_end;
          end
          default: begin
            seg.vert = 1'b1;
            seg.fix  = c_end;
            seg.lo   = CRD_W'(cmd_q.row_a);
            seg.hi   = r_end;
          end
        endcase
      end
      default: ;
    endcase
  end

  // columns past the right edge are clipped; an empty run or one wholly past the right edge is skipped
  assign seg_skip = seg.empty || (seg.vert ? (seg.fix >= COL_LIMIT) : (seg.lo >= COL_LIMIT));

  // --- pixel address and bit ---
  assign pix_col  = vert_q ? colfix_q : cur_q;
  assign page     = red_q >> 3;
  assign pix_addr = ADDR_W'(int'(page) * mfde_pkg::DISPLAY_COLUMNS + int'(pix_col));

  // previous cycle's write may hit the byte just read back
  assign pix_base  = (fwd_valid_q && (fwd_addr_q == pend_addr_q)) ? fwd_data_q : ram_rdata;
  assign pix_wdata = pix_base | pend_mask_q;

  // --- RAM port muxing ---
  always_comb begin
    if ((st_q == S_INIT) || (st_q == S_SWEEP)) begin
      ram_we    = 1'b1;
      ram_waddr = swp_q;
      ram_wdata = fill_q ? mfde_pkg::FILL_BYTE : mfde_pkg::CLEAR_BYTE;
    end else begin
      ram_we    = pend_valid_q;
      ram_waddr = pend_addr_q;
      ram_wdata = pix_wdata;
    end
    ram_re    = (st_q == S_DRAW) ||
                (cmd_fire && (cmd_i.data.command == mfde_pkg::CMD_STREAM) &&
                 (pos_q >= POS_W'(mfde_pkg::CURSOR_BYTES)));
    ram_raddr = (st_q == S_DRAW) ? pix_addr
                                 : ADDR_W'(pos_q - POS_W'(mfde_pkg::CURSOR_BYTES));
  end

  mfde_ram #(
    .Width (8),
    .Depth (mfde_pkg::STORE_BYTES)
  ) u_frame_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // --- sequencer ---
  always_comb begin
    st_d        = st_q;
    cmd_d       = cmd_q;
    res_d       = res_q;
    res_ram_d   = res_ram_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !res_o.ready;
    seg_idx_d   = seg_idx_q;
    swp_d       = swp_q;
    fill_d      = fill_q;
    pos_d       = pos_q;
    vert_d      = vert_q;
    cur_d       = cur_q;
    end_d       = end_q;
    colfix_d    = colfix_q;
    red_d       = red_q;
    pend_valid_d = 1'b0;
    pend_addr_d  = pend_addr_q;
    pend_mask_d  = pend_mask_q;

    case (st_q)
      S_INIT: begin
        swp_d = swp_q + ADDR_W'(1);
        if (swp_q == SWEEP_LAST) begin
          swp_d = '0;
          st_d  = S_IDLE;
        end
      end

      S_IDLE: begin
        if (cmd_fire) begin
          cmd_d     = cmd_i.data;
          res_d     = '0;
          res_ram_d = 1'b0;
          case (cmd_i.data.command)
            mfde_pkg::CMD_CLEAR, mfde_pkg::CMD_FILL: begin
              res_d.done_res = 1'b1;
              fill_d = (cmd_i.data.command == mfde_pkg::CMD_FILL);
              swp_d  = '0;
              st_d   = S_SWEEP;
            end
            mfde_pkg::CMD_POINT, mfde_pkg::CMD_LINE, mfde_pkg::CMD_RECT: begin
              res_d.done_res = 1'b1;
              seg_idx_d = '0;
              st_d      = S_SEG;
            end
            mfde_pkg::CMD_STREAM: begin
              if (pos_q == POS_W'(0)) begin
                res_d.out_byte = mfde_pkg::CURSOR_PAGE;
              end else if (pos_q == POS_W'(1)) begin
                res_d.out_byte = mfde_pkg::CURSOR_COL_HI;
              end else if (pos_q == POS_W'(2)) begin
                res_d.out_byte = mfde_pkg::CURSOR_COL_LO;
              end else begin
                res_ram_d        = 1'b1;  // RAM read issued this cycle
                res_d.is_data    = 1'b1;
                res_d.frame_last = (pos_q == POS_LAST);
              end
              pos_d = (pos_q == POS_LAST) ? '0 : pos_q + POS_W'(1);
              st_d  = S_RESP;
            end
            default: begin
              st_d = S_RESP;
            end
          endcase
        end
      end

      S_SWEEP: begin
        swp_d = swp_q + ADDR_W'(1);
        if (swp_q == SWEEP_LAST) begin
          swp_d = '0;
          st_d  = S_RESP;
        end
      end

      S_SEG: begin
        if (seg_skip) begin
          if (seg_last) begin
            st_d = S_RESP;
          end else begin
            seg_idx_d = seg_idx_q + 2'd1;
          end
        end else begin
          vert_d   = seg.vert;
          cur_d    = seg.lo;
          end_d    = (seg.vert || (seg.hi < COL_LIMIT)) ? seg.hi : COL_MAX;
          colfix_d = seg.fix;
          red_d    = seg.vert ? seg.lo : seg.fix;
          st_d     = S_WRAP;
        end
      end

      S_WRAP: begin
        if (red_q >= ROW_LIMIT) begin
          red_d = red_q - ROW_LIMIT;
        end else begin
          st_d = S_DRAW;
        end
      end

      S_DRAW: begin
        pend_valid_d = 1'b1;
        pend_addr_d  = pix_addr;
        pend_mask_d  = 8'b1 << red_q[2:0];
        cur_d        = cur_q + CRD_W'(1);
        if (vert_q) begin
          red_d = (red_q == ROW_MAX) ? '0 : red_q + CRD_W'(1);
        end
        if (cur_q == end_q) begin
          if (seg_last) begin
            st_d = S_RESP;
          end else begin
            seg_idx_d = seg_idx_q + 2'd1;
            st_d      = S_SEG;
          end
        end
      end

      S_RESP: begin
        if (out_free) begin
          out_d = res_q;
          if (res_ram_q) out_d.out_byte = ram_rdata;
          out_valid_d = 1'b1;
          st_d        = S_IDLE;
        end
      end

      default: begin
        st_d = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q         <= S_INIT;
      out_valid_q  <= 1'b0;
      seg_idx_q    <= '0;
      swp_q        <= '0;
      fill_q       <= 1'b0;
      pos_q        <= '0;
      pend_valid_q <= 1'b0;
      fwd_valid_q  <= 1'b0;
      res_ram_q    <= 1'b0;
    end else begin
      st_q         <= st_d;
      out_valid_q  <= out_valid_d;
      seg_idx_q    <= seg_idx_d;
      swp_q        <= swp_d;
      fill_q       <= fill_d;
      pos_q        <= pos_d;
      pend_valid_q <= pend_valid_d;
      fwd_valid_q  <= pend_valid_q;
      res_ram_q    <= res_ram_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    cmd_q       <= cmd_d;
    res_q       <= res_d;
    out_q       <= out_d;
    vert_q      <= vert_d;
    cur_q       <= cur_d;
    end_q       <= end_d;
    colfix_q    <= colfix_d;
    red_q       <= red_d;
    pend_addr_q <= pend_addr_d;
    pend_mask_q <= pend_mask_d;
    if (pend_valid_q) begin
      fwd_addr_q <= pend_addr_q;
      fwd_data_q <= pix_wdata;
    end
  end

  // --- assertions ---
  `MFDE_ASSERT(a_pos_in_frame, clk_i, rst_ni, pos_q <= POS_LAST)
  `MFDE_ASSERT(a_no_write_clash, clk_i, rst_ni, !(sweeping && pend_valid_q))
  `MFDE_ASSERT_NEXT(a_stream_resp, clk_i, rst_ni, stream_fire, st_q == S_RESP)
  `MFDE_ASSERT_NEXT(a_draw_reads_ram, clk_i, rst_ni, st_q == S_DRAW, pend_valid_q)

endmodule
